FILE: sv/pss_pkg.sv
// ============================================================================
// pss_pkg
// Shared types and constants of the permutation swap sequence block.
// ============================================================================
`default_nettype none

package pss_pkg;

  // Positions in a result are reported on a fixed five-bit field.
  localparam int unsigned POS_W = 5;

  // Controller states, one-hot coded.
  typedef enum logic [5:0] {
    S_LOAD = 6'b000001,
    S_RDT  = 6'b000010,
    S_CMP0 = 6'b000100,
    S_SCAN = 6'b001000,
    S_PUSH = 6'b010000,
    S_DONE = 6'b100000
  } pss_state_e;

  // One result as it sits in the output register.
  typedef struct packed {
    logic [POS_W-1:0] first_pos;
    logic [POS_W-1:0] second_pos;
    logic             has_swap;
    logic             end_of_run;
  } pss_result_t;

endpackage

`default_nettype wire

FILE: sv/pss_in_if.sv
// ============================================================================
// pss_in_if
// Input channel: one source id and one target id per transaction.
// ============================================================================
`default_nettype none

interface pss_in_if #(
  parameter int unsigned ID_BITS = 16
) ();

  logic               valid;
  logic               ready;
  logic [ID_BITS-1:0] source_id;
  logic [ID_BITS-1:0] target_id;
  logic               final_item;

  modport source (output valid, output source_id, output target_id,
                  output final_item, input ready);
  modport sink   (input valid, input source_id, input target_id,
                  input final_item, output ready);

endinterface

`default_nettype wire

FILE: sv/pss_out_if.sv
// ============================================================================
// pss_out_if
// Output channel: one swap (or the empty-run marker) per transaction.
// ============================================================================
`default_nettype none

interface pss_out_if import pss_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] first_pos;
  logic [POS_W-1:0] second_pos;
  logic             has_swap;
  logic             end_of_run;

  modport source (output valid, output first_pos, output second_pos,
                  output has_swap, output end_of_run, input ready);
  modport sink   (input valid, input first_pos, input second_pos,
                  input has_swap, input end_of_run, output ready);

endinterface

`default_nettype wire

FILE: sv/permutation_swap_sequence.sv
// ============================================================================
// permutation_swap_sequence
// Builds the list of position swaps that turns a source permutation into a
// target permutation.
// ============================================================================
// Usage: each input transaction on in_i carries one position of the source
// and of the target sequence. Transactions are taken one per cycle while the
// block is loading. The transaction with final_item set closes the run. Up to
// MAX_ITEMS positions are stored; further positions are dropped, although a
// final mark on a dropped transaction still closes the run.
// After the final transaction the block walks target positions i upward and
// scans the working copy from i for the same id. A match at j > i yields one
// output transaction (i, j), and working entry j takes the old entry at i. The
// last output of a run carries end_of_run; a run without swaps yields a
// single transaction with has_swap low and end_of_run high.
// Timing: for each position i the block reads target[i] and work[i] together,
// compares them, then scans the entries above i one by one through the single
// read port of the working-copy RAM, and on a match pushes the swap. The
// input is not ready during computation.
// Output: results leave through a registered stage; one swap is held back so
// the last one can be flagged. A stalled receiver stalls the scan at the next
// found swap while one swap is already held back. Reset clears the controller,
// the position count, the indexes i and j and the valid flags only; the RAMs
// need no clearing since only positions loaded in this run are read.
// ============================================================================
`default_nettype none

module permutation_swap_sequence import pss_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 32,
  parameter int unsigned ID_BITS   = 16
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  pss_in_if.sink   in_i,
  pss_out_if.source out_o
);

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  pss_state_e state_q, state_d;

  // Number of stored positions; during computation this is the run length.
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] i_q, i_d;
  logic [AW-1:0] j_q, j_d;

  // Id searched for at position i and the working entry at i.
  logic [ID_BITS-1:0] want_q, want_d;
  logic [ID_BITS-1:0] wi_q, wi_d;

  // Swap held back until it is known whether it is the last one.
  logic          pend_valid_q, pend_valid_d;
  logic [AW-1:0] pend_i_q, pend_i_d;
  logic [AW-1:0] pend_j_q, pend_j_d;
  logic [AW-1:0] cand_j_q, cand_j_d;

  // Output register.
  logic        out_valid_q;
  pss_result_t out_q;
  pss_result_t out_d;
  logic        out_load;
  logic        out_free;

  // RAM ports.
  logic               wrk_we, tgt_we, wrk_re, tgt_re;
  logic [AW-1:0]      wrk_waddr, wrk_raddr;
  logic [ID_BITS-1:0] wrk_wdata, wrk_rdata, tgt_rdata;

  logic          in_acc;
  logic          store_ok;
  logic [CW-1:0] i_next, j_next;
  logic          i_last, j_last;

  assign in_acc   = in_i.valid && in_i.ready;
  assign store_ok = (cnt_q < CW'(MAX_ITEMS));
  assign i_next   = CW'(i_q) + CW'(1);
  assign j_next   = CW'(j_q) + CW'(1);
  assign i_last   = (i_next == cnt_q);
  assign j_last   = (j_next == cnt_q);
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready = (state_q == S_LOAD);

  // Working copy of the source sequence.
  pss_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_ITEMS)) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (wrk_we),
    .waddr_i (wrk_waddr),
    .wdata_i (wrk_wdata),
    .re_i    (wrk_re),
    .raddr_i (wrk_raddr),
    .rdata_o (wrk_rdata)
  );

  // Copy of the target sequence; written only while loading.
  pss_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_ITEMS)) u_target_ram (
    .clk_i   (clk_i),
    .we_i    (tgt_we),
    .waddr_i (AW'(cnt_q)),
    .wdata_i (in_i.target_id),
    .re_i    (tgt_re),
    .raddr_i (i_q),
    .rdata_o (tgt_rdata)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    i_d          = i_q;
    j_d          = j_q;
    want_d       = want_q;
    wi_d         = wi_q;
    pend_valid_d = pend_valid_q;
    pend_i_d     = pend_i_q;
    pend_j_d     = pend_j_q;
    cand_j_d     = cand_j_q;
    out_load     = 1'b0;
    out_d        = '0;
    wrk_we       = 1'b0;
    tgt_we       = 1'b0;
    wrk_re       = 1'b0;
    tgt_re       = 1'b0;
    wrk_waddr    = AW'(cnt_q);
    wrk_wdata    = in_i.source_id;
    wrk_raddr    = i_q;

    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (store_ok) begin
            wrk_we = 1'b1;
            tgt_we = 1'b1;
            cnt_d  = cnt_q + CW'(1);
          end
          if (in_i.final_item) begin
            i_d     = '0;
            state_d = S_RDT;
          end
        end
      end

      S_RDT: begin
        // Fetch target[i] and work[i] together.
        wrk_re  = 1'b1;
        tgt_re  = 1'b1;
        state_d = S_CMP0;
      end

      S_CMP0: begin
        want_d = tgt_rdata;
        wi_d   = wrk_rdata;
        if ((wrk_rdata == tgt_rdata) || i_last) begin
          // Already in place, or nothing above i to search.
          if (i_last) begin
            state_d = S_DONE;
          end else begin
            i_d     = AW'(i_next);
            state_d = S_RDT;
          end
        end else begin
          wrk_re    = 1'b1;
          wrk_raddr = AW'(i_next);
          j_d       = AW'(i_next);
          state_d   = S_SCAN;
        end
      end

      S_SCAN: begin
        if (wrk_rdata == want_q) begin
          // Entry i is never read again, so only entry j is written back.
          wrk_we    = 1'b1;
          wrk_waddr = j_q;
          wrk_wdata = wi_q;
          cand_j_d  = j_q;
          state_d   = S_PUSH;
        end else if (j_last) begin
          if (i_last) begin
            state_d = S_DONE;
          end else begin
            i_d     = AW'(i_next);
            state_d = S_RDT;
          end
        end else begin
          wrk_re    = 1'b1;
          wrk_raddr = AW'(j_next);
          j_d       = AW'(j_next);
        end
      end

      S_PUSH: begin
        if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            out_load         = 1'b1;
            out_d.first_pos  = POS_W'(pend_i_q);
            out_d.second_pos = POS_W'(pend_j_q);
            out_d.has_swap   = 1'b1;
            out_d.end_of_run = 1'b0;
          end
          pend_valid_d = 1'b1;
          pend_i_d     = i_q;
          pend_j_d     = cand_j_q;
          if (i_last) begin
            state_d = S_DONE;
          end else begin
            i_d     = AW'(i_next);
            state_d = S_RDT;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_d.first_pos  = pend_valid_q ? POS_W'(pend_i_q) : '0;
          out_d.second_pos = pend_valid_q ? POS_W'(pend_j_q) : '0;
          out_d.has_swap   = pend_valid_q;
          out_d.end_of_run = 1'b1;
          pend_valid_d     = 1'b0;
          cnt_d            = '0;
          state_d          = S_LOAD;
        end
      end

      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      cnt_q        <= '0;
      i_q          <= '0;
      j_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      i_q          <= i_d;
      j_q          <= j_d;
      pend_valid_q <= pend_valid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    want_q   <= want_d;
    wi_q     <= wi_d;
    pend_i_q <= pend_i_d;
    pend_j_q <= pend_j_d;
    cand_j_q <= cand_j_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.first_pos  = out_q.first_pos;
  assign out_o.second_pos = out_q.second_pos;
  assign out_o.has_swap   = out_q.has_swap;
  assign out_o.end_of_run = out_q.end_of_run;

  // A swap is never held back across runs.
  a_pend_empty_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |-> !pend_valid_q)
    else $error("held-back swap left over while loading");

  // Write-back during the scan only lands above the current position.
  a_scan_write_above_i: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && wrk_we) |-> (j_q > i_q))
    else $error("swap write-back at or below current position");

  // The stored count never passes the capacity.
  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_ITEMS))
    else $error("position count beyond capacity");

  // A result without a swap only ever closes a run.
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.has_swap) |-> out_q.end_of_run)
    else $error("empty result not marked as end of run");

  // New output is only loaded when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

FILE: sv/pss_ram.sv
// ============================================================================
// pss_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
`default_nettype none

module pss_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ============================================================================
// tb
// Self-checking testbench of the permutation swap sequence block.
// ============================================================================
// A table of short directed runs comes first, then random runs of source and
// target sequences. A behavioral model in this file tracks the stored
// sequences and works out the swap list of every run. Each output
// transaction is compared with the oldest expected swap. Both channels idle
// at random, except during a calm window of the random part.
// ============================================================================
`default_nettype none

module tb;
  import pss_pkg::*;

  localparam int unsigned DEPTH        = 32;
  localparam int unsigned ID_W         = 16;
  localparam int unsigned ITEM_TARGET  = 170;
  localparam int unsigned DRAIN_CYCLES = 1200;
  localparam int unsigned IDLE_PCT     = 29;
  localparam int unsigned MAX_RUN_LEN  = 36;

  // Shape of the sequences in one random run.
  typedef enum int {
    SHAPE_PERM,
    SHAPE_BROKEN,
    SHAPE_NOISE,
    SHAPE_ROTATE
  } run_shape_e;

  // One row of the directed table. When typed is set on a final row, the
  // swap list of that run is the single result in want.
  typedef struct {
    logic [ID_W-1:0] src;
    logic [ID_W-1:0] tgt;
    logic            fin;
    logic            typed;
    pss_result_t     want;
  } step_row_t;

  localparam pss_result_t EMPTY_RUN = '{5'd0, 5'd0, 1'b0, 1'b1};
  localparam pss_result_t SWAP_0_1  = '{5'd0, 5'd1, 1'b1, 1'b1};
  localparam pss_result_t SWAP_0_2  = '{5'd0, 5'd2, 1'b1, 1'b1};
  localparam pss_result_t NO_TYPED  = '0;
  localparam int unsigned NROWS     = 14;

  // Directed runs: a lone item, a lone item whose id is missing, the widest
  // ids swapped, a three-way rotation, duplicate ids with a match in place,
  // a missing id after a swap, and a run that is already in order.
  step_row_t dir_rows [NROWS] = '{
    '{16'h0000, 16'h0000, 1'b1, 1'b1, EMPTY_RUN},
    '{16'hFFFF, 16'h0000, 1'b1, 1'b1, EMPTY_RUN},
    '{16'hFFFF, 16'h0000, 1'b0, 1'b0, NO_TYPED},
    '{16'h0000, 16'hFFFF, 1'b1, 1'b1, SWAP_0_1},
    '{16'hAAAA, 16'h5555, 1'b0, 1'b0, NO_TYPED},
    '{16'h5555, 16'h1234, 1'b0, 1'b0, NO_TYPED},
    '{16'h1234, 16'hAAAA, 1'b1, 1'b0, NO_TYPED},
    '{16'h0007, 16'h0003, 1'b0, 1'b0, NO_TYPED},
    '{16'h0007, 16'h0007, 1'b0, 1'b0, NO_TYPED},
    '{16'h0003, 16'h0007, 1'b1, 1'b1, SWAP_0_2},
    '{16'h0001, 16'h0002, 1'b0, 1'b0, NO_TYPED},
    '{16'h0002, 16'h0009, 1'b1, 1'b1, SWAP_0_1},
    '{16'h8001, 16'h8001, 1'b0, 1'b0, NO_TYPED},
    '{16'h7FFE, 16'h7FFE, 1'b1, 1'b1, EMPTY_RUN}
  };

  logic clk;
  logic rst_n;
  logic take_results = 1'b0;
  int   idle_pct     = IDLE_PCT;
  int   mismatches   = 0;
  int   run_no       = 0;

  // Model state: working copy of the source, copy of the target, and the
  // number of positions stored in the current run.
  logic [ID_W-1:0] work_ids   [DEPTH];
  logic [ID_W-1:0] target_ids [DEPTH];
  int unsigned     loaded     = 0;

  // Swaps that the block still owes, oldest first.
  pss_result_t swaps_due [$];

  pss_in_if #(.ID_BITS(ID_W)) in_ch ();
  pss_out_if out_ch ();

  assign out_ch.ready = take_results;

  permutation_swap_sequence #(
    .MAX_ITEMS(DEPTH),
    .ID_BITS  (ID_W)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Generous fixed limit, far above the slowest correct run.
  initial begin
    #16_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t run %0d: %s", $time, run_no, msg);
    mismatches++;
  endtask

  // Stores one position and, on a final item, walks the target positions,
  // searching the working copy for each id and recording every real swap.
  // Returns the number of results that the item adds.
  function automatic int track_item(input logic [ID_W-1:0] src,
                                    input logic [ID_W-1:0] tgt,
                                    input logic            fin);
    int          produced;
    logic [ID_W-1:0] want_id;
    logic [ID_W-1:0] held;
    pss_result_t swap;
    produced = 0;
    // A full store drops the position, but a final mark still counts.
    if (loaded < DEPTH) begin
      work_ids[loaded]   = src;
      target_ids[loaded] = tgt;
      loaded++;
    end
    if (!fin) return 0;
    for (int i = 0; i < int'(loaded); i++) begin
      want_id = target_ids[i];
      for (int j = i; j < int'(loaded); j++) begin
        if (work_ids[j] == want_id) begin
          // A match in place costs nothing; a match further up is a swap.
          if (j != i) begin
            held        = work_ids[i];
            work_ids[i] = work_ids[j];
            work_ids[j] = held;
            swap = '{POS_W'(i), POS_W'(j), 1'b1, 1'b0};
            swaps_due.push_back(swap);
            produced++;
          end
          break;
        end
      end
    end
    if (produced == 0) begin
      // A run without swaps still reports once, with the empty marker.
      swaps_due.push_back(EMPTY_RUN);
      produced = 1;
    end else begin
      swap = swaps_due.pop_back();
      swap.end_of_run = 1'b1;
      swaps_due.push_back(swap);
    end
    loaded = 0;
    return produced;
  endfunction

  // Offers one item, entered and left at a falling edge. Random idle cycles
  // come first; the model is updated at the edge that takes the transaction.
  task automatic send_item(input logic [ID_W-1:0] src,
                           input logic [ID_W-1:0] tgt,
                           input logic            fin,
                           input logic            typed,
                           input pss_result_t     want);
    int produced;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.source_id  <= src;
    in_ch.target_id  <= tgt;
    in_ch.final_item <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    produced = track_item(src, tgt, fin);
    if (typed && fin) begin
      // The table gives this run's result directly.
      repeat (produced) void'(swaps_due.pop_back());
      swaps_due.push_back(want);
    end
    @(negedge clk);
  endtask

  // Builds and sends one random run. Well-formed runs pair distinct ids with
  // a shuffle of themselves; broken runs spoil one or two target entries; noise
  // runs draw both sides from a tiny alphabet, which gives duplicates and
  // missing ids. A rotation forces the longest chain of swaps.
  task automatic play_run(input int len, input run_shape_e shape);
    logic [ID_W-1:0] src_ids [MAX_RUN_LEN];
    logic [ID_W-1:0] tgt_ids [MAX_RUN_LEN];
    logic [ID_W-1:0] held;
    logic            fresh;
    int              span;
    int              k;
    span = (len < int'(DEPTH)) ? len : int'(DEPTH);
    for (int i = 0; i < len; i++) begin
      if (shape == SHAPE_NOISE) begin
        src_ids[i] = ID_W'($urandom_range(3));
        tgt_ids[i] = ID_W'($urandom_range(3));
      end else begin
        fresh = 1'b0;
        while (!fresh) begin
          src_ids[i] = ID_W'($urandom_range(16'hFFFF));
          fresh = 1'b1;
          for (int m = 0; m < i; m++)
            if (src_ids[m] == src_ids[i]) fresh = 1'b0;
        end
        tgt_ids[i] = src_ids[i];
      end
    end
    if (shape == SHAPE_ROTATE) begin
      for (int i = 0; i < span; i++) tgt_ids[i] = src_ids[(i + 1) % span];
    end else if (shape != SHAPE_NOISE) begin
      for (int i = span - 1; i > 0; i--) begin
        k          = $urandom_range(i);
        held       = tgt_ids[i];
        tgt_ids[i] = tgt_ids[k];
        tgt_ids[k] = held;
      end
      if (shape == SHAPE_BROKEN) begin
        repeat ($urandom_range(2, 1)) begin
          k = $urandom_range(span - 1);
          tgt_ids[k] = ($urandom_range(1) == 1) ? ID_W'($urandom_range(16'hFFFF))
                                                 : tgt_ids[$urandom_range(span - 1)];
        end
      end
    end
    for (int i = 0; i < len; i++)
      send_item(src_ids[i], tgt_ids[i], i == len - 1, 1'b0, NO_TYPED);
  endtask

  // The receiver stalls at random, except while idle_pct is zero.
  always @(negedge clk) begin
    take_results <= ($urandom_range(99) >= idle_pct);
  end

  // Each result taken from the block is checked against the oldest swap due.
  always @(posedge clk) begin
    pss_result_t exp_swap;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (swaps_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result (%0d,%0d) has_swap=%0b end=%0b",
                                  out_ch.first_pos, out_ch.second_pos,
                                  out_ch.has_swap, out_ch.end_of_run));
      end else begin
        exp_swap = swaps_due.pop_front();
        if (out_ch.first_pos !== exp_swap.first_pos)
          report_mismatch($sformatf("first_pos got %0d expected %0d",
                                    out_ch.first_pos, exp_swap.first_pos));
        if (out_ch.second_pos !== exp_swap.second_pos)
          report_mismatch($sformatf("second_pos got %0d expected %0d",
                                    out_ch.second_pos, exp_swap.second_pos));
        if (out_ch.has_swap !== exp_swap.has_swap)
          report_mismatch($sformatf("has_swap got %0b expected %0b",
                                    out_ch.has_swap, exp_swap.has_swap));
        if (out_ch.end_of_run !== exp_swap.end_of_run)
          report_mismatch($sformatf("end_of_run got %0b expected %0b",
                                    out_ch.end_of_run, exp_swap.end_of_run));
      end
    end
  end

  initial begin
    int         items_sent;
    int         len;
    int         pick;
    run_shape_e shape;
    items_sent       = 0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.source_id  = '0;
    in_ch.target_id  = '0;
    in_ch.final_item = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table; a run ends at every final row.
    for (int r = 0; r < int'(NROWS); r++) begin
      send_item(dir_rows[r].src, dir_rows[r].tgt, dir_rows[r].fin,
                dir_rows[r].typed, dir_rows[r].want);
      if (dir_rows[r].fin) run_no++;
    end

    // The first random run overfills the store with a rotation, so the
    // final mark lands on a dropped transaction and 31 swaps come out.
    play_run(DEPTH + 2, SHAPE_ROTATE);
    run_no++;
    items_sent = int'(NROWS) + int'(DEPTH) + 2;

    while (items_sent < int'(ITEM_TARGET)) begin
      // A calm window with no idling on either side.
      idle_pct = (run_no >= 12 && run_no < 18) ? 0 : int'(IDLE_PCT);
      pick = $urandom_range(99);
      if (pick < 70)      len = $urandom_range(8, 1);
      else if (pick < 92) len = $urandom_range(DEPTH - 1, 9);
      else if (pick < 97) len = DEPTH;
      else                len = $urandom_range(MAX_RUN_LEN, DEPTH + 1);
      pick = $urandom_range(9);
      if (pick < 6)       shape = SHAPE_PERM;
      else if (pick < 8)  shape = SHAPE_BROKEN;
      else if (pick < 9)  shape = SHAPE_NOISE;
      else                shape = SHAPE_ROTATE;
      play_run(len, shape);
      run_no++;
      items_sent += len;
    end
    in_ch.valid <= 1'b0;

    while (swaps_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
